### sv/dpwm_pkg.sv
// dpwm_pkg: sizes, entry types and status codes of the demand paged word memory
// used by dpwm_ram instances in the top level and by demand_paged_word_memory_unit
// no dependencies
package dpwm_pkg;

    localparam int NUM_PAGES       = 16;
    localparam int NUM_LEAF_TABLES = 8;

    localparam int IDX_W  = 10;             // directory and leaf index width
    localparam int WORD_W = 10;             // word index inside a page
    localparam int DIR_SHIFT  = 22;
    localparam int LEAF_SHIFT = 12;

    localparam int TBL_W  = (NUM_LEAF_TABLES > 1) ? $clog2(NUM_LEAF_TABLES) : 1;
    localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int TCNT_W = $clog2(NUM_LEAF_TABLES + 1);
    localparam int PCNT_W = $clog2(NUM_PAGES + 1);

    localparam int DIR_AW  = IDX_W;
    localparam int LEAF_AW = TBL_W + IDX_W;
    localparam int PAGE_AW = PAGE_W + WORD_W;

    localparam int DIR_DEPTH  = 1 << IDX_W;
    localparam int LEAF_DEPTH = NUM_LEAF_TABLES << IDX_W;
    localparam int PAGE_DEPTH = NUM_PAGES << WORD_W;

    localparam int DIR_ENT_W  = 1 + TBL_W;
    localparam int LEAF_ENT_W = 1 + PAGE_W;

    // clear sweep covers the widest address space
    localparam int CLR_W0 = (LEAF_AW > DIR_AW) ? LEAF_AW : DIR_AW;
    localparam int CLR_W  = (PAGE_AW > CLR_W0) ? PAGE_AW : CLR_W0;

    typedef logic [TCNT_W-1:0] t_tcnt;
    typedef logic [PCNT_W-1:0] t_pcnt;
    typedef logic [CLR_W:0]    t_clr_ext;

    localparam t_tcnt TBL_LIMIT = TCNT_W'(NUM_LEAF_TABLES);
    localparam t_pcnt PG_LIMIT  = PCNT_W'(NUM_PAGES);

    localparam t_clr_ext DIR_END  = (CLR_W+1)'(DIR_DEPTH);
    localparam t_clr_ext LEAF_END = (CLR_W+1)'(LEAF_DEPTH);
    localparam t_clr_ext PAGE_END = (CLR_W+1)'(PAGE_DEPTH);

    typedef struct packed {
        logic             valid;
        logic [TBL_W-1:0] num;
    } t_dir_ent;

    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] num;
    } t_leaf_ent;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_MISALIGNED = 2'd1;
    localparam logic [1:0] ST_UNMAPPED   = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED  = 2'd3;

endpackage

### sv/dpwm_ram.sv
// dpwm_ram: simple dual port synchronous ram, one write and one registered read
// generic, no package dependencies
module dpwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/demand_paged_word_memory_unit.sv
// demand_paged_word_memory_unit: word memory behind a 10/10/12 two level table
// walk sequencer, allocation pools, counters and response register
// depends on dpwm_pkg and dpwm_ram
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+------------------------------------------
//  request | i_req_valid  | o_req_stall  | i_req_type, i_addr, i_store_data
//  result  | o_rsp_valid  | i_rsp_stall  | o_load_data, o_status, o_load_count,
//          |              |              | o_store_count
//
// a load result is registered after the directory, leaf table and page reads, each a
// synchronous memory read, and a store result after the directory and leaf table reads;
// a misaligned access goes straight to the final step. the walk is back in idle, where
// the next word is taken, as its result is registered.
// after reset a clearing pass writes all three memories, 2**CLR_W addresses (16384
// at the default pool sizes), while o_req_stall stays high.
// a waiting result does not block the next word; the walk only holds at its last
// step while the result register is still full and stalled.
module demand_paged_word_memory_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_addr,
    input  logic [31:0] i_store_data,
    output logic        o_rsp_valid,
    input  logic        i_rsp_stall,
    output logic [31:0] o_load_data,
    output logic [1:0]  o_status,
    output logic [31:0] o_load_count,
    output logic [31:0] o_store_count
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DIR  = 3'd2;
    localparam logic [2:0] S_LEAF = 3'd3;
    localparam logic [2:0] S_PAGE = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [dpwm_pkg::CLR_W-1:0] r_clr, n_clr;

    logic                          r_is_store, n_is_store;
    logic [dpwm_pkg::IDX_W-1:0]    r_dir_i, n_dir_i;
    logic [dpwm_pkg::IDX_W-1:0]    r_leaf_i, n_leaf_i;
    logic [dpwm_pkg::WORD_W-1:0]   r_word_i, n_word_i;
    logic [31:0]                   r_data, n_data;
    logic                          r_dir_ok, n_dir_ok;
    logic [dpwm_pkg::TBL_W-1:0]    r_table, n_table;
    logic [1:0]                    r_status, n_status;
    logic [31:0]                   r_ld, n_ld;

    dpwm_pkg::t_tcnt r_tbl_used, n_tbl_used;
    dpwm_pkg::t_pcnt r_pg_used, n_pg_used;
    logic [31:0]     r_load_cnt, n_load_cnt;
    logic [31:0]     r_store_cnt, n_store_cnt;

    logic        r_rsp_valid, n_rsp_valid;
    logic [31:0] r_rsp_ld, n_rsp_ld;
    logic [1:0]  r_rsp_status, n_rsp_status;
    logic [31:0] r_rsp_lcnt, n_rsp_lcnt;
    logic [31:0] r_rsp_scnt, n_rsp_scnt;

    // memory ports
    logic                         dir_we, leaf_we, page_we;
    logic [dpwm_pkg::DIR_AW-1:0]  dir_waddr;
    logic [dpwm_pkg::LEAF_AW-1:0] leaf_waddr, leaf_raddr;
    logic [dpwm_pkg::PAGE_AW-1:0] page_waddr, page_raddr;
    dpwm_pkg::t_dir_ent           dir_wdata, dir_rdata;
    dpwm_pkg::t_leaf_ent          leaf_wdata, leaf_rdata;
    logic [31:0]                  page_wdata, page_rdata;
    logic [dpwm_pkg::DIR_ENT_W-1:0]  dir_rvec;
    logic [dpwm_pkg::LEAF_ENT_W-1:0] leaf_rvec;

    logic                           req_acc;
    logic                           need_page;
    logic [dpwm_pkg::TBL_W-1:0]     table_sel;
    logic [dpwm_pkg::PAGE_W-1:0]    page_sel;
    dpwm_pkg::t_clr_ext             clr_ext;

    assign dir_rdata  = dir_rvec;
    assign leaf_rdata = leaf_rvec;
    assign req_acc    = i_req_valid && (r_state == S_IDLE);
    assign clr_ext    = {1'b0, r_clr};

    assign table_sel  = dir_rdata.valid ? dir_rdata.num
                                        : r_tbl_used[dpwm_pkg::TBL_W-1:0];
    assign need_page  = !(r_dir_ok && leaf_rdata.valid);
    assign page_sel   = need_page ? r_pg_used[dpwm_pkg::PAGE_W-1:0] : leaf_rdata.num;

    // read addresses are only consumed in the following walk state
    assign leaf_raddr = {table_sel, r_leaf_i};
    assign page_raddr = {leaf_rdata.num, r_word_i};

    dpwm_ram #(
        .WIDTH (dpwm_pkg::DIR_ENT_W),
        .DEPTH (dpwm_pkg::DIR_DEPTH),
        .AW    (dpwm_pkg::DIR_AW)
    ) u_dir (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_raddr (i_addr[dpwm_pkg::DIR_SHIFT +: dpwm_pkg::IDX_W]),
        .o_rdata (dir_rvec)
    );

    dpwm_ram #(
        .WIDTH (dpwm_pkg::LEAF_ENT_W),
        .DEPTH (dpwm_pkg::LEAF_DEPTH),
        .AW    (dpwm_pkg::LEAF_AW)
    ) u_leaf (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_waddr (leaf_waddr),
        .i_wdata (leaf_wdata),
        .i_raddr (leaf_raddr),
        .o_rdata (leaf_rvec)
    );

    dpwm_ram #(
        .WIDTH (32),
        .DEPTH (dpwm_pkg::PAGE_DEPTH),
        .AW    (dpwm_pkg::PAGE_AW)
    ) u_page (
        .i_clk   (i_clk),
        .i_we    (page_we),
        .i_waddr (page_waddr),
        .i_wdata (page_wdata),
        .i_raddr (page_raddr),
        .o_rdata (page_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_is_store   = r_is_store;
        n_dir_i      = r_dir_i;
        n_leaf_i     = r_leaf_i;
        n_word_i     = r_word_i;
        n_data       = r_data;
        n_dir_ok     = r_dir_ok;
        n_table      = r_table;
        n_status     = r_status;
        n_ld         = r_ld;
        n_tbl_used   = r_tbl_used;
        n_pg_used    = r_pg_used;
        n_load_cnt   = r_load_cnt;
        n_store_cnt  = r_store_cnt;
        n_rsp_valid  = r_rsp_valid;
        n_rsp_ld     = r_rsp_ld;
        n_rsp_status = r_rsp_status;
        n_rsp_lcnt   = r_rsp_lcnt;
        n_rsp_scnt   = r_rsp_scnt;

        dir_we     = 1'b0;
        dir_waddr  = r_dir_i;
        dir_wdata  = '0;
        leaf_we    = 1'b0;
        leaf_waddr = {r_table, r_leaf_i};
        leaf_wdata = '0;
        page_we    = 1'b0;
        page_waddr = {page_sel, r_word_i};
        page_wdata = r_data;

        if (r_rsp_valid && !i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                dir_we     = (clr_ext < dpwm_pkg::DIR_END);
                dir_waddr  = r_clr[dpwm_pkg::DIR_AW-1:0];
                leaf_we    = (clr_ext < dpwm_pkg::LEAF_END);
                leaf_waddr = r_clr[dpwm_pkg::LEAF_AW-1:0];
                page_we    = (clr_ext < dpwm_pkg::PAGE_END);
                page_waddr = r_clr[dpwm_pkg::PAGE_AW-1:0];
                page_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    n_is_store = i_req_type;
                    n_dir_i    = i_addr[dpwm_pkg::DIR_SHIFT +: dpwm_pkg::IDX_W];
                    n_leaf_i   = i_addr[dpwm_pkg::LEAF_SHIFT +: dpwm_pkg::IDX_W];
                    n_word_i   = i_addr[2 +: dpwm_pkg::WORD_W];
                    n_data     = i_store_data;
                    n_ld       = '0;
                    if (i_req_type) begin
                        if (r_store_cnt != '1) begin
                            n_store_cnt = r_store_cnt + 32'd1;
                        end
                    end else begin
                        if (r_load_cnt != '1) begin
                            n_load_cnt = r_load_cnt + 32'd1;
                        end
                    end
                    if (i_addr[1:0] != 2'b00) begin
                        n_status = dpwm_pkg::ST_MISALIGNED;
                        n_state  = S_FIN;
                    end else begin
                        n_status = dpwm_pkg::ST_OK;
                        n_state  = S_DIR;
                    end
                end
            end
            S_DIR: begin
                n_dir_ok = dir_rdata.valid;
                n_table  = table_sel;
                if (!dir_rdata.valid && !r_is_store) begin
                    n_status = dpwm_pkg::ST_UNMAPPED;
                    n_state  = S_FIN;
                end else if (!dir_rdata.valid && (r_tbl_used >= dpwm_pkg::TBL_LIMIT)) begin
                    n_status = dpwm_pkg::ST_EXHAUSTED;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_LEAF;
                end
            end
            S_LEAF: begin
                if (!r_is_store) begin
                    if (need_page) begin
                        n_status = dpwm_pkg::ST_UNMAPPED;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_PAGE;
                    end
                end else if (need_page && (r_pg_used >= dpwm_pkg::PG_LIMIT)) begin
                    n_status = dpwm_pkg::ST_EXHAUSTED;
                    n_state  = S_FIN;
                end else begin
                    // install table and page as needed, then write the word
                    if (!r_dir_ok) begin
                        dir_we          = 1'b1;
                        dir_wdata.valid = 1'b1;
                        dir_wdata.num   = r_table;
                        n_tbl_used      = r_tbl_used + 1'b1;
                    end
                    if (need_page) begin
                        leaf_we          = 1'b1;
                        leaf_wdata.valid = 1'b1;
                        leaf_wdata.num   = page_sel;
                        n_pg_used        = r_pg_used + 1'b1;
                    end
                    page_we = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_PAGE: begin
                n_ld    = page_rdata;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_rsp_valid || !i_rsp_stall) begin
                    n_rsp_valid  = 1'b1;
                    n_rsp_ld     = r_ld;
                    n_rsp_status = r_status;
                    n_rsp_lcnt   = r_load_cnt;
                    n_rsp_scnt   = r_store_cnt;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_tbl_used  <= '0;
            r_pg_used   <= '0;
            r_load_cnt  <= '0;
            r_store_cnt <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_tbl_used  <= n_tbl_used;
            r_pg_used   <= n_pg_used;
            r_load_cnt  <= n_load_cnt;
            r_store_cnt <= n_store_cnt;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_store   <= n_is_store;
        r_dir_i      <= n_dir_i;
        r_leaf_i     <= n_leaf_i;
        r_word_i     <= n_word_i;
        r_data       <= n_data;
        r_dir_ok     <= n_dir_ok;
        r_table      <= n_table;
        r_status     <= n_status;
        r_ld         <= n_ld;
        r_rsp_ld     <= n_rsp_ld;
        r_rsp_status <= n_rsp_status;
        r_rsp_lcnt   <= n_rsp_lcnt;
        r_rsp_scnt   <= n_rsp_scnt;
    end

    assign o_req_stall   = (r_state != S_IDLE);
    assign o_rsp_valid   = r_rsp_valid;
    assign o_load_data   = r_rsp_ld;
    assign o_status      = r_rsp_status;
    assign o_load_count  = r_rsp_lcnt;
    assign o_store_count = r_rsp_scnt;

    a_clr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> o_req_stall)
        else $error("word accepted during clearing pass");

    a_rsp_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside the final walk step");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_status != dpwm_pkg::ST_OK)) |-> (o_load_data == 32'd0))
        else $error("failed access returned nonzero data");

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pg_used <= dpwm_pkg::PG_LIMIT) && (r_tbl_used <= dpwm_pkg::TBL_LIMIT))
        else $error("allocation pool counter overran");

endmodule
